// ----- sv/swat_pkg.sv -----
// Shared types and constants for the send window / ack tracker.
// No dependencies; every other file in sv/ refers to this package.
`timescale 1ns / 1ps

package swat_pkg;

  localparam int unsigned SeqWidth  = 32;
  localparam int unsigned SizeWidth = 16;
  localparam int unsigned DupWidth  = 2;

  localparam logic [SeqWidth-1:0] SeqModulus  = 32'hFFFF_FFFF;
  localparam logic [SeqWidth-1:0] WindowReset = 32'd512000;
  localparam logic [SeqWidth-1:0] SeqReset    = 32'd1;
  localparam logic [DupWidth-1:0] DupLimit    = 2'd2;

  typedef enum logic [1:0] {
    CMD_HEADER = 2'd0,
    CMD_SENT   = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]           cmd;
    logic                 ack_flag;
    logic [SeqWidth-1:0]  ack_num;
    logic [SeqWidth-1:0]  adv_window;
    logic [SeqWidth-1:0]  seq_num;
    logic [SizeWidth-1:0] data_size;
  } req_t;

  typedef struct packed {
    logic [SeqWidth-1:0] next_send_seq;
    logic [SeqWidth-1:0] acked_through;
    logic [SeqWidth-1:0] sent_through;
    logic [SeqWidth-1:0] bytes_in_flight;
    logic [SeqWidth-1:0] peer_window_out;
    logic                retransmit;
    logic [SeqWidth-1:0] assigned_seq;
  } rsp_t;

  // handshake between the stages
  typedef struct packed {
    logic advance;  // held transaction moves into the result register this cycle
  } stage_ctl_t;

endpackage

// ----- sv/send_window_ack_tracker_core.sv -----
// Sender-side sequence tracker: cumulative ack, duplicate-ack fast retransmit.
// Top level; depends on swat_pkg, swat_input_stage, swat_state, swat_output_stage.
// One event per clock while nothing stalls: a header, a sent segment or an application
// write enters the input register and is applied to the tracker state at the edge that
// loads its result (the state after the update) into the result register. Throughput
// is one transaction per cycle unless the result channel stalls; the state update is
// combinational 32-bit compares and adds, so each event sees the effect of the one
// before. A stall on the result channel holds the result register; once the input
// register is also occupied the request channel stalls as well.
`timescale 1ns / 1ps

module send_window_ack_tracker_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  swat_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output swat_pkg::rsp_t rsp
);

  swat_pkg::stage_ctl_t ctl;
  swat_pkg::req_t       item;
  swat_pkg::rsp_t       result;
  logic                 free;

  swat_input_stage u_input (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .free      (free),
    .ctl       (ctl),
    .item      (item)
  );

  swat_state u_state (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

  swat_output_stage u_output (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .result    (result),
    .free      (free),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- sv/swat_input_stage.sv -----
// Input register for the request channel, with stall toward the sender.
// Depends on swat_pkg.
`timescale 1ns / 1ps

module swat_input_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  swat_pkg::req_t req,
  input  logic           free,
  output swat_pkg::stage_ctl_t ctl,
  output swat_pkg::req_t item
);

  logic valid;

  assign ctl.advance = valid && free;
  // hold only while the held transaction cannot move on
  assign req_stall   = valid && !free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!req_stall) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      item <= req;
    end
  end

endmodule

// ----- sv/swat_state.sv -----
// Tracker state registers and the per-event update logic.
// Depends on swat_pkg. Produces the result for the item being retired.
`timescale 1ns / 1ps

module swat_state (
  input  logic                 clk,
  input  logic                 rst,
  input  swat_pkg::stage_ctl_t ctl,
  input  swat_pkg::req_t       item,
  output swat_pkg::rsp_t       result
);

  localparam int unsigned W  = swat_pkg::SeqWidth;
  localparam int unsigned DW = swat_pkg::DupWidth;

  logic [W-1:0]  last_acked, last_acked_next;
  logic [W-1:0]  last_sent, last_sent_next;
  logic [W-1:0]  next_to_send, next_to_send_next;
  logic [W-1:0]  next_write_seq, next_write_seq_next;
  logic [W-1:0]  in_flight, in_flight_next;
  logic [W-1:0]  peer_window, peer_window_next;
  logic [DW-1:0] dup_count, dup_count_next;
  logic [W-1:0]  dup_ack_value, dup_ack_value_next;

  logic [W-1:0]  acked;
  logic [DW-1:0] dup_inc;
  logic [W-1:0]  size_ext;
  logic [W-1:0]  seg_end;
  logic [W-1:0]  seg_next;
  logic [W-1:0]  write_sum;
  logic          rewind;
  logic [W-1:0]  given;

  assign acked     = item.ack_num - W'(1);
  assign dup_inc   = dup_count + DW'(1);
  assign size_ext  = W'(item.data_size);
  assign seg_next  = item.seq_num + size_ext;
  assign seg_end   = seg_next - W'(1);
  assign write_sum = next_write_seq + size_ext;

  always_comb begin
    last_acked_next     = last_acked;
    last_sent_next      = last_sent;
    next_to_send_next   = next_to_send;
    next_write_seq_next = next_write_seq;
    in_flight_next      = in_flight;
    peer_window_next    = peer_window;
    dup_count_next      = dup_count;
    dup_ack_value_next  = dup_ack_value;
    rewind              = 1'b0;
    given               = '0;
    case (item.cmd)
      swat_pkg::CMD_HEADER: begin
        peer_window_next = item.adv_window;
        if (item.ack_flag) begin
          if (last_acked < acked) begin
            in_flight_next     = in_flight - (acked - last_acked);
            last_acked_next    = acked;
            dup_count_next     = '0;
            dup_ack_value_next = item.ack_num;
          end else if (dup_ack_value == item.ack_num) begin
            // third identical ack: rewind to it
            if (dup_inc >= swat_pkg::DupLimit) begin
              dup_count_next    = '0;
              next_to_send_next = item.ack_num;
              rewind            = 1'b1;
            end else begin
              dup_count_next = dup_inc;
            end
          end else begin
            dup_ack_value_next = item.ack_num;
            dup_count_next     = '0;
          end
        end
      end
      swat_pkg::CMD_SENT: begin
        if (seg_end > last_sent) begin
          last_sent_next = seg_end;
          in_flight_next = in_flight + size_ext;
        end
        if (item.seq_num == next_to_send) begin
          next_to_send_next = seg_next;
        end
      end
      swat_pkg::CMD_WRITE: begin
        given = next_write_seq;
        // sum wraps modulo 2^32; only the all-ones value then folds to zero
        next_write_seq_next = (write_sum == swat_pkg::SeqModulus) ? '0 : write_sum;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.next_send_seq   = next_to_send_next;
    result.acked_through   = last_acked_next;
    result.sent_through    = last_sent_next;
    result.bytes_in_flight = in_flight_next;
    result.peer_window_out = peer_window_next;
    result.retransmit      = rewind;
    result.assigned_seq    = given;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_acked     <= '0;
      last_sent      <= '0;
      next_to_send   <= swat_pkg::SeqReset;
      next_write_seq <= swat_pkg::SeqReset;
      in_flight      <= '0;
      peer_window    <= swat_pkg::WindowReset;
      dup_count      <= '0;
      dup_ack_value  <= '0;
    end else if (ctl.advance) begin
      last_acked     <= last_acked_next;
      last_sent      <= last_sent_next;
      next_to_send   <= next_to_send_next;
      next_write_seq <= next_write_seq_next;
      in_flight      <= in_flight_next;
      peer_window    <= peer_window_next;
      dup_count      <= dup_count_next;
      dup_ack_value  <= dup_ack_value_next;
    end
  end

endmodule

// ----- sv/swat_output_stage.sv -----
// Result register for the response channel.
// Depends on swat_pkg.
`timescale 1ns / 1ps

module swat_output_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  swat_pkg::stage_ctl_t ctl,
  input  swat_pkg::rsp_t       result,
  output logic                 free,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output swat_pkg::rsp_t       rsp
);

  // register can take a new result when empty or being drained this cycle
  assign free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (free) begin
      rsp_valid <= ctl.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      rsp <= result;
    end
  end

endmodule
